### hw/rtl/rmq_pkg.sv
package rmq_pkg;

    // fixed point format of matrix and quaternion
    localparam int FRAC_BITS = 14;
    localparam int ELEM_W    = 16;

    // square root unit: radicand, root and one stage per root bit
    localparam int SQ_IN_W    = 17;
    localparam int SQ_ROOT_W  = 17;
    localparam int SQ_STAGES  = SQ_ROOT_W;

    // divider unit: numerator, denominator and one stage per quotient bit
    localparam int DIV_NUM_W  = 32;
    localparam int DIV_DEN_W  = SQ_ROOT_W + 1;
    localparam int DIV_Q_W    = 24;
    localparam int DIV_STAGES = DIV_Q_W;

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_xx;
        logic signed [ELEM_W-1:0] elem_xy;
        logic signed [ELEM_W-1:0] elem_xz;
        logic signed [ELEM_W-1:0] elem_yx;
        logic signed [ELEM_W-1:0] elem_yy;
        logic signed [ELEM_W-1:0] elem_yz;
        logic signed [ELEM_W-1:0] elem_zx;
        logic signed [ELEM_W-1:0] elem_zy;
        logic signed [ELEM_W-1:0] elem_zz;
    } t_in_word;

    typedef struct packed {
        logic signed [ELEM_W-1:0] quat_w;
        logic signed [ELEM_W-1:0] quat_x;
        logic signed [ELEM_W-1:0] quat_y;
        logic signed [ELEM_W-1:0] quat_z;
        logic                     bad_matrix;
    } t_out_word;

endpackage

### hw/rtl/rmq_sqrt.sv
module rmq_sqrt
    import rmq_pkg::*;
(
    input  logic                 i_clk,
    input  logic [SQ_IN_W-1:0]   i_rad,
    output logic [SQ_ROOT_W-1:0] o_root
);

    localparam int NW    = 2 * SQ_STAGES;
    localparam int REM_W = SQ_ROOT_W + 2;

    logic [REM_W-1:0]     r_rem  [SQ_STAGES];
    logic [SQ_ROOT_W-1:0] r_root [SQ_STAGES];
    logic [NW-1:0]        r_n    [SQ_STAGES];

    // one root bit per stage, two radicand bits brought down each time
    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
        logic [REM_W-1:0]     p_rem;
        logic [SQ_ROOT_W-1:0] p_root;
        logic [NW-1:0]        p_n;
        logic [REM_W+1:0]     cur;
        logic [REM_W+1:0]     trial;

        if (g == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_n    = NW'(i_rad) << (FRAC_BITS + 2);
        end else begin : g_next
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_n    = r_n[g-1];
        end

        assign cur   = {p_rem, p_n[NW-1-2*g -: 2]};
        assign trial = (REM_W + 2)'({p_root, 2'b01});

        always_ff @(posedge i_clk) begin
            if (cur >= trial) begin
                r_rem[g]  <= REM_W'(cur - trial);
                r_root[g] <= {p_root[SQ_ROOT_W-2:0], 1'b1};
            end else begin
                r_rem[g]  <= REM_W'(cur);
                r_root[g] <= {p_root[SQ_ROOT_W-2:0], 1'b0};
            end
            r_n[g] <= p_n;
        end
    end

    assign o_root = r_root[SQ_STAGES-1];

endmodule

### hw/rtl/rmq_div.sv
module rmq_div
    import rmq_pkg::*;
(
    input  logic                 i_clk,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic [DIV_Q_W-1:0]   o_quot
);

    logic [DIV_DEN_W-1:0] r_rem [DIV_STAGES];
    logic [DIV_DEN_W-1:0] r_den [DIV_STAGES];
    logic [DIV_NUM_W-1:0] r_num [DIV_STAGES];
    logic [DIV_Q_W-1:0]   r_q   [DIV_STAGES];

    // restoring division, one quotient bit per stage
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic [DIV_DEN_W-1:0] p_rem;
        logic [DIV_DEN_W-1:0] p_den;
        logic [DIV_NUM_W-1:0] p_num;
        logic [DIV_Q_W-1:0]   p_q;
        logic [DIV_DEN_W:0]   cur;

        if (g == 0) begin : g_first
            assign p_rem = DIV_DEN_W'(i_num[DIV_NUM_W-1:DIV_Q_W]);
            assign p_den = i_den;
            assign p_num = i_num;
            assign p_q   = '0;
        end else begin : g_next
            assign p_rem = r_rem[g-1];
            assign p_den = r_den[g-1];
            assign p_num = r_num[g-1];
            assign p_q   = r_q[g-1];
        end

        assign cur = {p_rem, p_num[DIV_Q_W-1-g]};

        always_ff @(posedge i_clk) begin
            if (cur >= {1'b0, p_den}) begin
                r_rem[g] <= DIV_DEN_W'(cur - {1'b0, p_den});
                r_q[g]   <= {p_q[DIV_Q_W-2:0], 1'b1};
            end else begin
                r_rem[g] <= DIV_DEN_W'(cur);
                r_q[g]   <= {p_q[DIV_Q_W-2:0], 1'b0};
            end
            r_den[g] <= p_den;
            r_num[g] <= p_num;
        end
    end

    assign o_quot = r_q[DIV_STAGES-1];

endmodule

### hw/rtl/rotation_matrix_to_quaternion.sv
// stages in order: input, front, square root, divider operands, dividers, output
// throughput: one matrix per cycle, busy never rises
// the depth is set by the 17 stage square root and the 24 stage dividers
// reset (synchronous, active low) clears the valid bits only
// results cannot be stalled by the receiver
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_word,
    output logic      o_valid,
    output t_out_word o_word
);

    localparam int TR_W = ELEM_W + 2;
    localparam int RD_W = ELEM_W + 3;
    localparam int MG_W = ELEM_W + 1;
    localparam logic signed [RD_W-1:0] ONE = RD_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        SEL_TRACE,
        SEL_X,
        SEL_Y,
        SEL_Z
    } t_sel;

    typedef struct packed {
        t_sel                   sel;
        logic                   bad;
        logic signed [TR_W-1:0] d0;
        logic signed [TR_W-1:0] d1;
        logic signed [TR_W-1:0] d2;
    } t_front;

    typedef struct packed {
        t_sel                sel;
        logic                bad;
        logic [2:0]          neg;
        logic [ELEM_W-1:0]   quarter;
    } t_back;

    // magnitude of a quotient made signed and saturated
    function automatic logic [ELEM_W-1:0] sat_q(input logic neg, input logic [DIV_Q_W-1:0] q);
        logic [DIV_Q_W-1:0] lim;
        begin
            lim = neg ? DIV_Q_W'(32768) : DIV_Q_W'(32767);
            if (q > lim)
                sat_q = neg ? ELEM_W'(32768) : ELEM_W'(32767);
            else
                sat_q = neg ? ELEM_W'(-q) : q[ELEM_W-1:0];
        end
    endfunction

    assign busy = 1'b0;

    // input register
    t_in_word r_in;
    logic     r_v_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in <= 1'b0;
        end else begin
            r_v_in <= start;
        end
        r_in <= i_word;
    end

    // branch choice, radicand and off-diagonal pairs
    logic signed [TR_W-1:0] xx, xy, xz, yx, yy, yz, zx, zy, zz, trace;
    logic signed [RD_W-1:0] rad;
    t_front                 n_front;

    assign xx = TR_W'(r_in.elem_xx);
    assign xy = TR_W'(r_in.elem_xy);
    assign xz = TR_W'(r_in.elem_xz);
    assign yx = TR_W'(r_in.elem_yx);
    assign yy = TR_W'(r_in.elem_yy);
    assign yz = TR_W'(r_in.elem_yz);
    assign zx = TR_W'(r_in.elem_zx);
    assign zy = TR_W'(r_in.elem_zy);
    assign zz = TR_W'(r_in.elem_zz);
    assign trace = xx + yy + zz;

    always_comb begin
        if (trace > 0) begin
            n_front.sel = SEL_TRACE;
            rad         = RD_W'(trace) + ONE;
            n_front.d0  = zy - yz;
            n_front.d1  = xz - zx;
            n_front.d2  = yx - xy;
        end else if (xx > yy && xx > zz) begin
            n_front.sel = SEL_X;
            rad         = ONE + RD_W'(xx) - RD_W'(yy) - RD_W'(zz);
            n_front.d0  = zy - yz;
            n_front.d1  = xy + yx;
            n_front.d2  = xz + zx;
        end else if (yy > zz) begin
            n_front.sel = SEL_Y;
            rad         = ONE + RD_W'(yy) - RD_W'(xx) - RD_W'(zz);
            n_front.d0  = xz - zx;
            n_front.d1  = xy + yx;
            n_front.d2  = yz + zy;
        end else begin
            n_front.sel = SEL_Z;
            rad         = ONE + RD_W'(zz) - RD_W'(xx) - RD_W'(yy);
            n_front.d0  = yx - xy;
            n_front.d1  = xz + zx;
            n_front.d2  = yz + zy;
        end
        n_front.bad = (rad <= 0);
    end

    t_front             r_front;
    logic [SQ_IN_W-1:0] r_rad;
    logic               r_v_front;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_front <= 1'b0;
        end else begin
            r_v_front <= r_v_in;
        end
        r_front <= n_front;
        r_rad   <= rad[SQ_IN_W-1:0];
    end

    // square root of the radicand scaled to s
    logic [SQ_ROOT_W-1:0] root;

    rmq_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r_rad),
        .o_root (root)
    );

    t_front r_sb_a [SQ_STAGES];
    logic   r_v_a  [SQ_STAGES];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SQ_STAGES; k++) begin
            if (!i_rst_n) begin
                r_v_a[k] <= 1'b0;
            end else begin
                r_v_a[k] <= (k == 0) ? r_v_front : r_v_a[k-1];
            end
            r_sb_a[k] <= (k == 0) ? r_front : r_sb_a[k-1];
        end
    end

    // divider operands: (2 |d| one + s) / (2 s), signs set aside
    t_front               sb_s;
    logic [MG_W-1:0]      mag [3];
    logic [2:0]           neg;
    logic [DIV_NUM_W-1:0] n_num [3];
    t_back                n_back;

    assign sb_s = r_sb_a[SQ_STAGES-1];

    always_comb begin
        neg[0] = sb_s.d0 < 0;
        neg[1] = sb_s.d1 < 0;
        neg[2] = sb_s.d2 < 0;
        mag[0] = neg[0] ? MG_W'(-sb_s.d0) : MG_W'(sb_s.d0);
        mag[1] = neg[1] ? MG_W'(-sb_s.d1) : MG_W'(sb_s.d1);
        mag[2] = neg[2] ? MG_W'(-sb_s.d2) : MG_W'(sb_s.d2);
        for (int k = 0; k < 3; k++) begin
            n_num[k] = (DIV_NUM_W'(mag[k]) << (FRAC_BITS + 1)) + DIV_NUM_W'(root);
        end
        n_back.sel     = sb_s.sel;
        n_back.bad     = sb_s.bad;
        n_back.neg     = neg;
        n_back.quarter = ELEM_W'((root + SQ_ROOT_W'(2)) >> 2);
    end

    logic [DIV_NUM_W-1:0] r_num [3];
    logic [DIV_DEN_W-1:0] r_den;
    t_back                r_back;
    logic                 r_v_prep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_prep <= 1'b0;
        end else begin
            r_v_prep <= r_v_a[SQ_STAGES-1];
        end
        r_num  <= n_num;
        r_den  <= {root, 1'b0};
        r_back <= n_back;
    end

    // three dividers side by side
    logic [DIV_Q_W-1:0] quot [3];

    for (genvar c = 0; c < 3; c++) begin : g_div
        rmq_div u_div (
            .i_clk  (i_clk),
            .i_num  (r_num[c]),
            .i_den  (r_den),
            .o_quot (quot[c])
        );
    end

    t_back r_sb_b [DIV_STAGES];
    logic  r_v_b  [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (!i_rst_n) begin
                r_v_b[k] <= 1'b0;
            end else begin
                r_v_b[k] <= (k == 0) ? r_v_prep : r_v_b[k-1];
            end
            r_sb_b[k] <= (k == 0) ? r_back : r_sb_b[k-1];
        end
    end

    // saturate and place the components
    t_back             sb_q;
    logic [ELEM_W-1:0] c0, c1, c2;
    t_out_word         n_word;

    assign sb_q = r_sb_b[DIV_STAGES-1];
    assign c0   = sat_q(sb_q.neg[0], quot[0]);
    assign c1   = sat_q(sb_q.neg[1], quot[1]);
    assign c2   = sat_q(sb_q.neg[2], quot[2]);

    always_comb begin
        unique case (sb_q.sel)
            SEL_TRACE: begin
                n_word.quat_w = sb_q.quarter;
                n_word.quat_x = c0;
                n_word.quat_y = c1;
                n_word.quat_z = c2;
            end
            SEL_X: begin
                n_word.quat_w = c0;
                n_word.quat_x = sb_q.quarter;
                n_word.quat_y = c1;
                n_word.quat_z = c2;
            end
            SEL_Y: begin
                n_word.quat_w = c0;
                n_word.quat_x = c1;
                n_word.quat_y = sb_q.quarter;
                n_word.quat_z = c2;
            end
            default: begin
                n_word.quat_w = c0;
                n_word.quat_x = c1;
                n_word.quat_y = c2;
                n_word.quat_z = sb_q.quarter;
            end
        endcase
        n_word.bad_matrix = sb_q.bad;
        if (sb_q.bad) begin
            n_word.quat_w = '0;
            n_word.quat_x = '0;
            n_word.quat_y = '0;
            n_word.quat_z = '0;
        end
    end

    // output register
    t_out_word r_word;
    logic      r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_v_b[DIV_STAGES-1];
        end
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

### hw/rtl/rmq_checker.sv
module rmq_checker
    import rmq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_valid,
    input t_out_word o_word
);

    localparam int LATENCY = 45;

    // never holds off a new word
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // every accepted word gives one result after the pipeline depth
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_valid)
        else $error("result missing");

    // no result without a word accepted earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("unexpected result");

    // a bad matrix gives an all zero quaternion
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.bad_matrix) |->
            (o_word.quat_w == '0 && o_word.quat_x == '0 &&
             o_word.quat_y == '0 && o_word.quat_z == '0))
        else $error("bad matrix result not zero");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_word  (o_word)
);

### tb/sv/tb_rotation_matrix_to_quaternion.sv
`timescale 1ns / 100ps

module tb_rotation_matrix_to_quaternion
    import rmq_pkg::*;
();

    localparam int LATENCY   = 45;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 1400;
    localparam int ONE_Q     = 1 << FRAC_BITS;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_word  i_word;
    logic      o_valid;
    t_out_word o_word;

    t_in_word  pending_mats[$];
    t_out_word expected_quats[$];
    int        err_count;
    int        idle_cycles;
    bit        feed_done;
    bit        hold_for_drain;

    rotation_matrix_to_quaternion uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_word  (i_word),
        .o_valid (o_valid),
        .o_word  (o_word)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // integer square root, floor
    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // d * one / s, nearest, ties away from zero
    function automatic longint div_round(longint d, longint unsigned s);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : d;
        q = (2 * (mag << FRAC_BITS) + s) / (2 * s);
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [ELEM_W-1:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[ELEM_W-1:0];
    endfunction

    // quaternion expected for one matrix
    function automatic t_out_word matrix_to_quat(t_in_word m);
        longint xx, xy, xz, yx, yy, yz, zx, zy, zz, tr, rad, qtr, one_l;
        longint w, x, y, z;
        longint unsigned s;
        int branch;
        t_out_word q;
        one_l = longint'(ONE_Q);
        xx = longint'(m.elem_xx); xy = longint'(m.elem_xy); xz = longint'(m.elem_xz);
        yx = longint'(m.elem_yx); yy = longint'(m.elem_yy); yz = longint'(m.elem_yz);
        zx = longint'(m.elem_zx); zy = longint'(m.elem_zy); zz = longint'(m.elem_zz);
        tr = xx + yy + zz;
        q = '0;
        if (tr > 0) begin
            branch = 0; rad = tr + one_l;
        end else if (xx > yy && xx > zz) begin
            branch = 1; rad = one_l + xx - yy - zz;
        end else if (yy > zz) begin
            branch = 2; rad = one_l + yy - xx - zz;
        end else begin
            branch = 3; rad = one_l + zz - xx - yy;
        end
        if (rad <= 0) begin
            q.bad_matrix = 1'b1;
            return q;
        end
        s = root_floor(longint'(rad) << (FRAC_BITS + 2));
        qtr = (s + 2) >> 2;
        case (branch)
            0: begin
                w = qtr; x = div_round(zy - yz, s);
                y = div_round(xz - zx, s); z = div_round(yx - xy, s);
            end
            1: begin
                w = div_round(zy - yz, s); x = qtr;
                y = div_round(xy + yx, s); z = div_round(xz + zx, s);
            end
            2: begin
                w = div_round(xz - zx, s); x = div_round(xy + yx, s);
                y = qtr; z = div_round(yz + zy, s);
            end
            default: begin
                w = div_round(yx - xy, s); x = div_round(xz + zx, s);
                y = div_round(yz + zy, s); z = qtr;
            end
        endcase
        q.quat_w = clamp16(w);
        q.quat_x = clamp16(x);
        q.quat_y = clamp16(y);
        q.quat_z = clamp16(z);
        return q;
    endfunction

    function automatic t_in_word mk(int a, int b, int c, int d, int e, int f,
                                    int g, int h, int k);
        t_in_word m;
        m.elem_xx = ELEM_W'(a); m.elem_xy = ELEM_W'(b); m.elem_xz = ELEM_W'(c);
        m.elem_yx = ELEM_W'(d); m.elem_yy = ELEM_W'(e); m.elem_yz = ELEM_W'(f);
        m.elem_zx = ELEM_W'(g); m.elem_zy = ELEM_W'(h); m.elem_zz = ELEM_W'(k);
        return m;
    endfunction

    function automatic logic signed [ELEM_W-1:0] rnd_elem();
        case ($urandom_range(0, 5))
            0: return ELEM_W'($urandom);
            1: return ELEM_W'(32767 - $urandom_range(0, 3));
            2: return ELEM_W'(-32768 + $urandom_range(0, 3));
            default: return ELEM_W'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
        endcase
    endfunction

    // rotation-like matrix: one or all diagonals non-negative, others non-positive, off-diagonals within +-one
    function automatic t_in_word rnd_rotation();
        t_in_word m;
        int sel;
        m = '0;
        m.elem_xy = ELEM_W'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
        m.elem_xz = ELEM_W'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
        m.elem_yx = ELEM_W'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
        m.elem_yz = ELEM_W'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
        m.elem_zx = ELEM_W'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
        m.elem_zy = ELEM_W'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
        sel = int'($urandom_range(0, 3));
        m.elem_xx = ELEM_W'($urandom_range(0, ONE_Q) - ONE_Q);
        m.elem_yy = ELEM_W'($urandom_range(0, ONE_Q) - ONE_Q);
        m.elem_zz = ELEM_W'($urandom_range(0, ONE_Q) - ONE_Q);
        case (sel)
            0: begin
                m.elem_xx = ELEM_W'($urandom_range(0, ONE_Q));
                m.elem_yy = ELEM_W'($urandom_range(0, ONE_Q));
                m.elem_zz = ELEM_W'($urandom_range(0, ONE_Q));
            end
            1: m.elem_xx = ELEM_W'($urandom_range(0, ONE_Q));
            2: m.elem_yy = ELEM_W'($urandom_range(0, ONE_Q));
            default: m.elem_zz = ELEM_W'($urandom_range(0, ONE_Q));
        endcase
        return m;
    endfunction

    // driver: bursts and gaps, inputs change on the falling edge
    int burst_left;
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // hold the word until taken
        end else if (hold_for_drain && expected_quats.size() != 0) begin
            start <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end else if (pending_mats.size() != 0) begin
            i_word <= pending_mats.pop_front();
            start <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            start <= 1'b0;
        end
    end

    // monitor: predict on accepted words, check strobed results
    always @(posedge i_clk) begin
        t_out_word exp_q;
        if (i_rst_n) begin
            if (start && !busy) expected_quats.push_back(matrix_to_quat(i_word));
            if (o_valid) begin
                if (expected_quats.size() == 0) begin
                    $error("unexpected result word %h", o_word);
                    err_count++;
                end else begin
                    exp_q = expected_quats.pop_front();
                    if (o_word.quat_w !== exp_q.quat_w) begin
                        $error("quat_w exp %0d got %0d", exp_q.quat_w, o_word.quat_w);
                        err_count++;
                    end
                    if (o_word.quat_x !== exp_q.quat_x) begin
                        $error("quat_x exp %0d got %0d", exp_q.quat_x, o_word.quat_x);
                        err_count++;
                    end
                    if (o_word.quat_y !== exp_q.quat_y) begin
                        $error("quat_y exp %0d got %0d", exp_q.quat_y, o_word.quat_y);
                        err_count++;
                    end
                    if (o_word.quat_z !== exp_q.quat_z) begin
                        $error("quat_z exp %0d got %0d", exp_q.quat_z, o_word.quat_z);
                        err_count++;
                    end
                    if (o_word.bad_matrix !== exp_q.bad_matrix) begin
                        $error("bad_matrix exp %0b got %0b", exp_q.bad_matrix,
                               o_word.bad_matrix);
                        err_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no accepted word in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (!(feed_done && expected_quats.size() == 0)) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        start = 1'b0;
        i_word = '0;
        i_rst_n = 1'b0;
        err_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        feed_done = 1'b0;
        hold_for_drain = 1'b0;

        // directed: identity, half turns, field extremes, ties
        pending_mats.push_back(mk(ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q));
        pending_mats.push_back(mk(ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q));
        pending_mats.push_back(mk(-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q));
        pending_mats.push_back(mk(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q));
        pending_mats.push_back(mk(0, -ONE_Q, 0, ONE_Q, 0, 0, 0, 0, ONE_Q));
        pending_mats.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_mats.push_back(mk(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q));
        pending_mats.push_back(mk(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
        pending_mats.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767,
                                  32767, 32767, 32767));
        pending_mats.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768));
        pending_mats.push_back(mk(-32768, 32767, -32768, 32767, -32768, 32767,
                                  -32768, 32767, -32768));
        pending_mats.push_back(mk(-ONE_Q, 32767, -32768, -32768, -ONE_Q, 32767,
                                  32767, -32768, -ONE_Q + 1));
        pending_mats.push_back(mk(-100, 0, 0, 0, -100, 0, 0, 0, -100));
        pending_mats.push_back(mk(-ONE_Q + 1, 5, 7, 3, -ONE_Q, 1, 9, 2, -ONE_Q));
        pending_mats.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0, -1));
        pending_mats.push_back(mk(0, 1, 1, 0, 0, 1, 0, 0, 0));
        pending_mats.push_back(mk(-3000, 20000, -5000, 1234, -3000, 777,
                                  -9999, 4321, -3000));
        pending_mats.push_back(mk(-32768, 0, 0, 0, 32767, 0, 0, 0, 32767));
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 3) == 0)
                pending_mats.push_back(mk(rnd_elem(), rnd_elem(), rnd_elem(),
                    rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(),
                    rnd_elem()));
            else
                pending_mats.push_back(rnd_rotation());
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // let the pipe drain fully once midway
        wait (pending_mats.size() < N_RANDOM / 2);
        hold_for_drain = 1'b1;
        // a word already on the ports is taken before the wait starts
        repeat (2) @(negedge i_clk);
        wait (expected_quats.size() == 0);
        @(negedge i_clk);
        hold_for_drain = 1'b0;

        wait (pending_mats.size() == 0);
        @(posedge i_clk);
        feed_done = 1'b1;
        wait (expected_quats.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_sqrt.sv
hw/rtl/rmq_div.sv
hw/rtl/rotation_matrix_to_quaternion.sv
hw/rtl/rmq_checker.sv
tb/sv/tb_rotation_matrix_to_quaternion.sv
